// ===== design/nsf_pkg.sv =====
`default_nettype none

package nsf_pkg;

  // Framing characters.
  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_UPA   = 8'h41;  // 'A'

  localparam logic [3:0] NIBBLE_MASK = 4'hF;
  localparam logic [3:0] DEC_DIGITS  = 4'd10;

  // Room kept back in the sentence buffer for '*', two check characters and the end.
  localparam int LIMIT_MARGIN = 5;

  localparam int BUFFER_BYTES_DEF = 128;

  localparam int LEN_W = 7;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_CHK1 = 2'd2,
    PH_CHK2 = 2'd3
  } phase_e;

  typedef struct packed {
    logic             done;
    logic             good;
    logic [LEN_W-1:0] len;
  } nsf_result_t;

  // Upper-case hex character of one nibble.
  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NIBBLE_MASK;
    if (n < DEC_DIGITS) begin
      hex_upper = CHAR_ZERO + {4'd0, n};
    end else begin
      hex_upper = CHAR_UPA + {4'd0, n - DEC_DIGITS};
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/nsf_in_if.sv =====
`default_nettype none

interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/nsf_out_if.sv =====
`default_nettype none

interface nsf_out_if;
  logic       valid;
  logic       ready;
  logic       sentence_done;
  logic       checksum_good;
  logic [6:0] sentence_length;

  modport source (output valid, output sentence_done, output checksum_good,
                  output sentence_length, input ready);
  modport sink   (input valid, input sentence_done, input checksum_good,
                  input sentence_length, output ready);
endinterface

`default_nettype wire

// ===== design/nsf_framer_core.sv =====
`default_nettype none

module nsf_framer_core #(
  parameter int BUFFER_BYTES = nsf_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           byte_i,
  output nsf_pkg::nsf_result_t      res_o
);
  import nsf_pkg::*;

  localparam int CntW = $clog2(BUFFER_BYTES);
  localparam logic [CntW-1:0] Limit = CntW'(BUFFER_BYTES - LIMIT_MARGIN);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      first_q, first_d;
  logic [31:0]     len_full;
  logic            hi_ok, lo_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      xor_q   <= '0;
      first_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      first_q <= first_d;
    end
  end

  assign hi_ok    = (first_q == hex_upper(xor_q[7:4]));
  assign lo_ok    = (byte_i == hex_upper(xor_q[3:0]));
  assign len_full = 32'(cnt_q) + 32'd1;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    xor_d      = xor_q;
    first_d    = first_q;
    res_o.done = 1'b0;
    res_o.good = 1'b0;
    res_o.len  = '0;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == CHAR_START) begin
          phase_d = PH_BODY;
          cnt_d   = CntW'(1);
          xor_d   = '0;
        end
      end
      PH_BODY: begin
        if (byte_i == CHAR_START) begin
          cnt_d = CntW'(1);
          xor_d = '0;
        end else if (cnt_q >= Limit) begin
          // Sentence too long for the buffer: drop it.
          phase_d = PH_HUNT;
          cnt_d   = '0;
          xor_d   = '0;
        end else begin
          cnt_d = cnt_q + CntW'(1);
          if (byte_i == CHAR_STAR) begin
            phase_d = PH_CHK1;
          end else begin
            xor_d = xor_q ^ byte_i;
          end
        end
      end
      PH_CHK1: begin
        first_d = byte_i;
        cnt_d   = cnt_q + CntW'(1);
        phase_d = PH_CHK2;
      end
      default: begin
        res_o.done = 1'b1;
        if (hi_ok && lo_ok) begin
          res_o.good = 1'b1;
          res_o.len  = len_full[LEN_W-1:0];
        end
        phase_d = PH_HUNT;
        cnt_d   = '0;
        xor_d   = '0;
      end
    endcase
  end

  a_chk1_then_chk2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_CHK1 |=> phase_q == PH_CHK2)
    else $error("first check character did not lead to the second");

  a_done_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done |=> phase_q == PH_HUNT && cnt_q == '0 && xor_q == '0)
    else $error("finished sentence did not return to hunting");

  a_body_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> cnt_q != '0 && cnt_q <= Limit)
    else $error("payload byte count out of range");

  a_good_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.good |-> res_o.done && phase_q == PH_CHK2)
    else $error("good checksum flagged outside the second check character");

endmodule

`default_nettype wire

// ===== design/nmea_sentence_framer.sv =====
// Timing: a word accepted on rx_i is caught in the input register, then passes through
//   the result register to res_o, when res_o is not stalled.
// Throughput: one word per cycle while res_o is not stalled; the framing state updates once per byte.
// Each received byte yields exactly one result word.
// Reset (rst_ni, asynchronous, active low) empties both registers and returns the
//   framer to hunting for '$' with count, XOR and first check character cleared.
`default_nettype none

module nmea_sentence_framer #(
  parameter int BUFFER_BYTES = nsf_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nsf_in_if.sink      rx_i,
  nsf_out_if.source   res_o
);
  import nsf_pkg::*;

  // Input register: holds the byte that the framer works on next.
  logic        s1_vld_q, s1_vld_d;
  logic [7:0]  s1_byte_q, s1_byte_d;

  // Result register: holds the result word until the sink takes it.
  logic        out_vld_q, out_vld_d;
  nsf_result_t out_q, out_d;

  nsf_result_t core_res;
  logic        advance;
  logic        step;
  logic        in_ready;

  // The pipeline moves whenever the result register is empty or being drained.
  assign advance  = !out_vld_q || res_o.ready;
  assign step     = s1_vld_q && advance;
  assign in_ready = !s1_vld_q || advance;

  assign rx_i.ready = in_ready;

  always_comb begin
    s1_vld_d  = s1_vld_q;
    s1_byte_d = s1_byte_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (in_ready) begin
      s1_vld_d  = rx_i.valid;
      s1_byte_d = rx_i.rx_byte;
    end
    if (advance) begin
      out_vld_d = s1_vld_q;
      out_d     = core_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    out_q     <= out_d;
  end

  // The framer state advances only when its byte moves into the result register.
  nsf_framer_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .res_o  (core_res)
  );

  assign res_o.valid           = out_vld_q;
  assign res_o.sentence_done   = out_q.done;
  assign res_o.checksum_good   = out_q.good;
  assign res_o.sentence_length = out_q.len;

endmodule

`default_nettype wire

// ===== sim/nmea_sentence_framer_checker.sv =====
`timescale 1ns / 100ps

module nmea_sentence_framer_checker #(
  parameter int BUFFER_BYTES = nsf_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nsf_in_if         rx_i,
  nsf_out_if        res_i,
  output int        fail_count_o,
  output int        pending_o
);
  import nsf_pkg::*;

  // Framer state as it should be after every accepted byte.
  phase_e     phase_q;
  int         count_q;
  logic [7:0] xor_q;
  logic [7:0] first_chk_q;

  nsf_result_t expected_results[$];

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CHAR_ZERO + {4'd0, n};
    end
    return (CHAR_UPA - 8'd10) + {4'd0, n};
  endfunction

  // Advances the framer by one byte and returns the result word it must produce.
  function automatic nsf_result_t frame_byte(input logic [7:0] b);
    nsf_result_t r;
    r = '0;
    case (phase_q)
      PH_HUNT: begin
        if (b == CHAR_START) begin
          phase_q = PH_BODY;
          count_q = 1;
          xor_q   = '0;
        end
      end
      PH_BODY: begin
        if (b == CHAR_START) begin
          count_q = 1;
          xor_q   = '0;
        end else if (count_q >= BUFFER_BYTES - LIMIT_MARGIN) begin
          phase_q = PH_HUNT;
          count_q = 0;
          xor_q   = '0;
        end else begin
          count_q++;
          if (b == CHAR_STAR) begin
            phase_q = PH_CHK1;
          end else begin
            xor_q = xor_q ^ b;
          end
        end
      end
      PH_CHK1: begin
        first_chk_q = b;
        count_q++;
        phase_q = PH_CHK2;
      end
      default: begin
        r.done = 1'b1;
        if (first_chk_q == nibble_char(xor_q[7:4]) && b == nibble_char(xor_q[3:0])) begin
          r.good = 1'b1;
          r.len  = LEN_W'(count_q + 1);
        end
        phase_q = PH_HUNT;
        count_q = 0;
        xor_q   = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    nsf_result_t want;
    if (!rst_ni) begin
      phase_q      = PH_HUNT;
      count_q      = 0;
      xor_q        = '0;
      first_chk_q  = '0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word done=%0b good=%0b len=%0d", $time,
                   res_i.sentence_done, res_i.checksum_good, res_i.sentence_length);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (res_i.sentence_done !== want.done || res_i.checksum_good !== want.good ||
              res_i.sentence_length !== want.len) begin
            $display("%0t: expected done=%0b good=%0b len=%0d, got done=%0b good=%0b len=%0d",
                     $time, want.done, want.good, want.len, res_i.sentence_done,
                     res_i.checksum_good, res_i.sentence_length);
            fail_count_o++;
          end
        end
      end
      if (rx_i.valid && rx_i.ready) begin
        expected_results.push_back(frame_byte(rx_i.rx_byte));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== sim/nmea_sentence_framer_test.sv =====
`timescale 1ns / 100ps

module nmea_sentence_framer_test;
  import nsf_pkg::*;

  localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int RANDOM_WORDS = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  // Two register stages inside the block, plus a safety margin.
  localparam int DRAIN_CYCLES = 20;

  // Receiver stall patterns.
  localparam int STALL_NONE     = 0;
  localparam int STALL_HALF     = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  // Ways to spoil a checksum.
  localparam int BAD_HI_BIT = 0;
  localparam int BAD_LO_BIT = 1;
  localparam int BAD_START  = 2;
  localparam int BAD_LOWER  = 3;

  logic clk_i;
  logic rst_ni;

  nsf_in_if  rx_if ();
  nsf_out_if res_if ();

  int fail_count;
  int pending_count;
  int rx_accepts;
  int words_sent;
  int burst_left;
  int cycle_count = 0;

  // Bytes of the sentence that is being put together before it is sent.
  logic [7:0] frame_q[$];

  nmea_sentence_framer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  // The checker watches both channels, predicts every result word and compares.
  nmea_sentence_framer_checker #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_i       (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Counts accepted input words. It is sampled at the falling edge, where it is stable,
  // so the sender never has to look at ready inside the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_accepts <= 0;
    end else if (rx_if.valid && rx_if.ready) begin
      rx_accepts <= rx_accepts + 1;
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiver switches between stall patterns at random intervals, so that
  // stretches of full speed alternate with light, heavy and regular back pressure.
  initial begin : res_ready_gen
    int stall_mode;
    int mode_left;
    res_if.ready = 1'b0;
    stall_mode   = STALL_NONE;
    mode_left    = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  res_if.ready = 1'b1;
        STALL_HALF:  res_if.ready = 1'($urandom_range(0, 1));
        STALL_HEAVY: res_if.ready = ($urandom_range(0, 3) == 0);
        default:     res_if.ready = (cycle_count % 3 != 0);
      endcase
    end
  end

  // Sends one word and returns at the falling edge after it was accepted. The sender
  // works in bursts; between bursts valid drops for a random number of cycles, which
  // may be zero so that bursts also run back to back. Valid stays high from one word
  // to the next inside a burst.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int target;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        rx_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    rx_if.rx_byte = b;
    rx_if.valid   = 1'b1;
    target = words_sent + 1;
    do @(negedge clk_i); while (rx_accepts < target);
    words_sent = target;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_byte(frame_q[i]);
    end
    frame_q.delete();
  endtask

  // Any byte that neither opens nor closes a sentence.
  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_START || c == CHAR_STAR);
    return c;
  endfunction

  // Appends n payload bytes to the frame and folds them into the checksum.
  task automatic add_payload(input int n, inout logic [7:0] sum);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = payload_char();
      frame_q.push_back(c);
      sum ^= c;
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + {4'd0, n} : CHAR_UPA + {4'd0, n} - 8'd10;
  endfunction

  initial begin : stimulus
    int         pick;
    int         body_len;
    int         framed_words;
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;

    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    burst_left    = 0;
    words_sent    = 0;
    framed_words  = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // While hunting, the extremes of the byte range and a stray '*' are ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_STAR);
    // The shortest good sentence: empty payload, checksum 00.
    send_text("$*00");
    // A second '$' in the payload restarts the sentence; only "$B*42" counts.
    send_text("$A$B*42");
    // A '$' in the checksum position is only a checksum character, so this is bad.
    send_text("$*$0");
    // Payload byte FF, with a lower-case digit in the checksum, which must be rejected.
    send_text("$\377*Ff");

    // Random part. Most traffic is well-formed sentences with random content; the
    // rest is line noise, spoiled checksums, cut-off sentences and sentences long
    // enough to run into the buffer limit.
    while (framed_words < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      sum  = '0;
      if (pick < 8) begin
        // Noise: any byte value, which may itself open a sentence.
        repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame();
      end else begin
        frame_q.push_back(CHAR_START);
        if (pick < 12) begin
          // Payload lengths around the buffer limit: the two longest that fit and the
          // first two that get the sentence dropped.
          body_len = BUF_BYTES - LIMIT_MARGIN - 3 + $urandom_range(0, 3);
        end else begin
          body_len = $urandom_range(0, 15);
        end
        if (pick >= 12 && pick < 20) begin
          add_payload($urandom_range(0, 6), sum);
          frame_q.push_back(CHAR_START);
          sum = '0;
        end
        add_payload(body_len, sum);
        frame_q.push_back(CHAR_STAR);
        hi = hex_char(sum[7:4]);
        lo = hex_char(sum[3:0]);
        if (pick >= 20 && pick < 32) begin
          case ($urandom_range(BAD_HI_BIT, BAD_LOWER))
            BAD_HI_BIT: hi = hi ^ (8'd1 << $urandom_range(0, 7));
            BAD_LO_BIT: lo = lo ^ (8'd1 << $urandom_range(0, 7));
            BAD_START:  hi = CHAR_START;
            default:    lo = lo | 8'h20;
          endcase
        end
        frame_q.push_back(hi);
        // A cut-off sentence lacks its last character; the next byte takes its place.
        if (pick < 32 || pick >= 36) begin
          frame_q.push_back(lo);
        end
        framed_words += frame_q.size();
        send_frame();
      end
    end
    rx_if.valid = 1'b0;

    // Wait for every outstanding result word, then a little longer so that any
    // word the block should not produce has a chance to show up.
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
